>>> sv/pqec_pkg.sv
// ----------------------------------------------------------------------------
// pqec_pkg: shared types, palette and helpers for the palette quantizer
// Holds the fixed 16-entry palette, channel and error widths, and the
// candidate type used by the nearest-color compare tree.
// ----------------------------------------------------------------------------
package pqec_pkg;

   localparam int PAL_DEPTH        = 16;
   localparam int PAL_IDX_W        = 4;
   localparam int PALETTE_SIZE_DEF = 16;
   localparam int CH_W             = 8;
   localparam int ERR_W            = 11;
   localparam int SUM_W            = 12;
   localparam int KEY_W            = 24;
   localparam int ADJ_MIN          = -512;
   localparam int ADJ_MAX          = 767;
   localparam int ERR_LIM          = 767;
   localparam int REQ_TDATA_W      = 24;
   localparam int RSP_TDATA_W      = 32;
   localparam int RSP_PAD_W        = RSP_TDATA_W - 3 * CH_W - PAL_IDX_W;

   localparam logic [CH_W-1:0] PAL_RED [PAL_DEPTH] = '{
      8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255,
      8'd128, 8'd0, 8'd128, 8'd128, 8'd0, 8'd0, 8'd128, 8'd64};
   localparam logic [CH_W-1:0] PAL_GREEN [PAL_DEPTH] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd128, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd64};
   localparam logic [CH_W-1:0] PAL_BLUE [PAL_DEPTH] = '{
      8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
      8'd128, 8'd128, 8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd64};

   typedef logic signed [ERR_W-1:0] s11_type;

   typedef struct packed {
      s11_type red;
      s11_type green;
      s11_type blue;
   } rgb_s11_type;

   typedef struct packed {
      logic                        valid;
      logic [PAL_IDX_W-1:0]        idx;
      logic signed [KEY_W-1:0]     key;
   } cand_type;

   typedef struct packed {
      logic [PAL_IDX_W-1:0] idx;
      logic [CH_W-1:0]      red;
      logic [CH_W-1:0]      green;
      logic [CH_W-1:0]      blue;
      rgb_s11_type          err;
   } choice_type;

   // Keep the left (lower index) candidate unless it is invalid or the right one is strictly closer.
   function automatic cand_type pick(cand_type a, cand_type b);
      cand_type w;
      w = a;
      if (b.valid && (!a.valid || (b.key < a.key))) begin
         w = b;
      end
      return w;
   endfunction

endpackage

>>> sv/pqec_adjust.sv
// ----------------------------------------------------------------------------
// pqec_adjust: add carried error to a pixel and saturate
// Each channel gets its error added and is clamped to -512..767.
// ----------------------------------------------------------------------------
module pqec_adjust (
   input  logic [pqec_pkg::CH_W-1:0] red,
   input  logic [pqec_pkg::CH_W-1:0] green,
   input  logic [pqec_pkg::CH_W-1:0] blue,
   input  pqec_pkg::rgb_s11_type     err,
   output pqec_pkg::rgb_s11_type     adj
);

   function automatic pqec_pkg::s11_type sat_add(logic [pqec_pkg::CH_W-1:0] px,
                                                 pqec_pkg::s11_type e);
      logic signed [pqec_pkg::SUM_W-1:0] s;
      pqec_pkg::s11_type                 r;
      s = signed'({{(pqec_pkg::SUM_W - pqec_pkg::CH_W){1'b0}}, px})
          + pqec_pkg::SUM_W'(e);
      if (s < pqec_pkg::SUM_W'(pqec_pkg::ADJ_MIN)) begin
         r = pqec_pkg::ERR_W'(pqec_pkg::ADJ_MIN);
      end else if (s > pqec_pkg::SUM_W'(pqec_pkg::ADJ_MAX)) begin
         r = pqec_pkg::ERR_W'(pqec_pkg::ADJ_MAX);
      end else begin
         r = s[pqec_pkg::ERR_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      adj.red   = sat_add(red, err.red);
      adj.green = sat_add(green, err.green);
      adj.blue  = sat_add(blue, err.blue);
   end

endmodule

>>> sv/pqec_search.sv
// ----------------------------------------------------------------------------
// pqec_search: nearest palette entry and new carried error
// Ranks entries by |c|^2 - 2 p.c (same order as squared distance), reduces
// with a four-level compare tree, lowest index on ties.
// ----------------------------------------------------------------------------
module pqec_search #(
   parameter int PALETTE_SIZE = pqec_pkg::PALETTE_SIZE_DEF
) (
   input  pqec_pkg::rgb_s11_type adj,
   output pqec_pkg::choice_type  choice
);

   localparam int KW = pqec_pkg::KEY_W;

   pqec_pkg::cand_type cand [pqec_pkg::PAL_DEPTH];
   pqec_pkg::cand_type lvl1 [8];
   pqec_pkg::cand_type lvl2 [4];
   pqec_pkg::cand_type lvl3 [2];
   pqec_pkg::cand_type best;

   // Palette terms are constants, so the products reduce to shifts and adds.
   always_comb begin
      logic signed [KW-1:0] r_x, g_x, b_x, cr, cg, cb, dot, csq;
      r_x = KW'(adj.red);
      g_x = KW'(adj.green);
      b_x = KW'(adj.blue);
      for (int i = 0; i < pqec_pkg::PAL_DEPTH; i++) begin
         cr  = signed'(KW'(pqec_pkg::PAL_RED[i]));
         cg  = signed'(KW'(pqec_pkg::PAL_GREEN[i]));
         cb  = signed'(KW'(pqec_pkg::PAL_BLUE[i]));
         dot = r_x * cr + g_x * cg + b_x * cb;
         csq = cr * cr + cg * cg + cb * cb;
         cand[i].valid = (i == 0) || (i < PALETTE_SIZE);
         cand[i].idx   = pqec_pkg::PAL_IDX_W'(i);
         cand[i].key   = csq - (dot <<< 1);
      end
   end

   always_comb begin
      for (int j = 0; j < 8; j++) lvl1[j] = pqec_pkg::pick(cand[2*j], cand[2*j+1]);
      for (int j = 0; j < 4; j++) lvl2[j] = pqec_pkg::pick(lvl1[2*j], lvl1[2*j+1]);
      for (int j = 0; j < 2; j++) lvl3[j] = pqec_pkg::pick(lvl2[2*j], lvl2[2*j+1]);
      best = pqec_pkg::pick(lvl3[0], lvl3[1]);
   end

   always_comb begin
      choice.idx   = best.idx;
      choice.red   = pqec_pkg::PAL_RED[best.idx];
      choice.green = pqec_pkg::PAL_GREEN[best.idx];
      choice.blue  = pqec_pkg::PAL_BLUE[best.idx];
      choice.err.red   = adj.red   - signed'({3'b000, choice.red});
      choice.err.green = adj.green - signed'({3'b000, choice.green});
      choice.err.blue  = adj.blue  - signed'({3'b000, choice.blue});
   end

endmodule

>>> sv/palette_quantizer_error_carry.sv
// ----------------------------------------------------------------------------
// palette_quantizer_error_carry: nearest palette color with carried error
// Path: a req transfer is captured in the input register; the pixel then
//   moves into the result register, which drives rsp_tvalid.
// Throughput: one pixel per cycle while the result can drain; the error loop
//   (adjust, search, error register) holds one register, which sets that rate.
// Reset: synchronous, clears both valid flags and the carried error.
// ----------------------------------------------------------------------------
module palette_quantizer_error_carry #(
   parameter int PALETTE_SIZE = pqec_pkg::PALETTE_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: red_in [7:0], green_in [15:8], blue_in [23:16]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pqec_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // rsp_tdata: red_out [7:0], green_out [15:8], blue_out [23:16],
   //            palette_index [27:24], zero fill [31:28]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pqec_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int CW = pqec_pkg::CH_W;

   // Input register stage
   logic          in_valid_ff, in_valid_in;
   logic [CW-1:0] in_red_ff, in_green_ff, in_blue_ff;

   // Carried error and result register
   pqec_pkg::rgb_s11_type err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pqec_pkg::choice_type  rsp_ff;

   pqec_pkg::rgb_s11_type adj;
   pqec_pkg::choice_type  choice;
   logic                  advance;
   logic                  req_xfer;

   // Move the staged pixel into the result register whenever it is free or draining.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Update the carried error only when the pixel that produced it moves on.
      err_in = advance ? choice.err : err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         err_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         err_ff       <= err_in;
      end
   end

   // Payload registers: hold while stalled, no reset needed.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_red_ff   <= req_tdata[CW-1:0];
         in_green_ff <= req_tdata[2*CW-1:CW];
         in_blue_ff  <= req_tdata[3*CW-1:2*CW];
      end
      if (advance) begin
         rsp_ff <= choice;
      end
   end

   pqec_adjust u_adjust (
      .red   (in_red_ff),
      .green (in_green_ff),
      .blue  (in_blue_ff),
      .err   (err_ff),
      .adj   (adj)
   );

   pqec_search #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_search (
      .adj    (adj),
      .choice (choice)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{pqec_pkg::RSP_PAD_W{1'b0}}, rsp_ff.idx,
                        rsp_ff.blue, rsp_ff.green, rsp_ff.red};

   // Carried error stays within the range the clamp guarantees.
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      (err_ff.red   >= -pqec_pkg::ERR_LIM) && (err_ff.red   <= pqec_pkg::ERR_LIM) &&
      (err_ff.green >= -pqec_pkg::ERR_LIM) && (err_ff.green <= pqec_pkg::ERR_LIM) &&
      (err_ff.blue  >= -pqec_pkg::ERR_LIM) && (err_ff.blue  <= pqec_pkg::ERR_LIM))
      else $error("carried error out of range");

   // Error changes only when a pixel advances into the result register.
   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(err_ff))
      else $error("carried error changed without a pixel advancing");

   // A shown result names a searched entry and carries that entry's color.
   a_rsp_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (int'(rsp_ff.idx) < PALETTE_SIZE || rsp_ff.idx == '0) &&
         rsp_ff.red   == pqec_pkg::PAL_RED[rsp_ff.idx] &&
         rsp_ff.green == pqec_pkg::PAL_GREEN[rsp_ff.idx] &&
         rsp_ff.blue  == pqec_pkg::PAL_BLUE[rsp_ff.idx])
      else $error("result color does not match its palette index");

   // A pixel advancing always leaves a valid result behind.
   a_adv_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced pixel produced no result");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for palette_quantizer_error_carry
// Drives RGB pixels over the req stream and checks every rsp transfer
// against an in-bench nearest-color predictor that carries its own
// per-channel error. A directed table covers the palette colors, the tie
// rule and error build-up. Random raster-like traffic follows, under three
// idle patterns, one long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int NUM_DIRECTED  = 25;
   localparam int PHASE_ITEMS   = 300;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 8;

   // One quantized result: chosen palette entry and its color.
   typedef struct packed {
      logic [pqec_pkg::PAL_IDX_W-1:0] index;
      logic [pqec_pkg::CH_W-1:0]      red;
      logic [pqec_pkg::CH_W-1:0]      green;
      logic [pqec_pkg::CH_W-1:0]      blue;
   } pick_type;

   // Directed row: input pixel, plus a hand-typed result when pinned is set.
   typedef struct packed {
      logic [pqec_pkg::CH_W-1:0] red;
      logic [pqec_pkg::CH_W-1:0] green;
      logic [pqec_pkg::CH_W-1:0] blue;
      logic                      pinned;
      pick_type                  want;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;

   // req_tdata: red_in [7:0], green_in [15:8], blue_in [23:16]
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [pqec_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   // rsp_tdata: red_out [7:0], green_out [15:8], blue_out [23:16],
   //            palette_index [27:24], zero fill [31:28]
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [pqec_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Sideband that rides along with req_tdata: a typed expectation, if any.
   logic     pin_valid = 1'b0;
   pick_type pin_want  = '0;

   // Carried error of the predictor, one per channel.
   pqec_pkg::s11_type carry_red   = '0;
   pqec_pkg::s11_type carry_green = '0;
   pqec_pkg::s11_type carry_blue  = '0;

   pick_type pending_picks [$];
   pick_type predicted;
   pick_type arrived_want;
   int       mismatch_count = 0;
   int       cycle_count    = 0;

   // Idle percentages and the long hold-off request, set by the main sequence.
   int src_idle_pct  = 0;
   int snk_idle_pct  = 0;
   int hold_request  = 0;
   int hold_left     = 0;

   // Raster ramp state for gradient-like traffic.
   logic [pqec_pkg::CH_W-1:0] ramp_red   = '0;
   logic [pqec_pkg::CH_W-1:0] ramp_green = '0;
   logic [pqec_pkg::CH_W-1:0] ramp_blue  = '0;

   stim_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      // exact palette colors from a clean error: nothing carries over
      '{8'd0,   8'd0,   8'd0,   1'b1, '{4'd0,  8'd0,   8'd0,   8'd0  }},
      '{8'd255, 8'd255, 8'd255, 1'b1, '{4'd7,  8'd255, 8'd255, 8'd255}},
      '{8'd255, 8'd0,   8'd0,   1'b1, '{4'd2,  8'd255, 8'd0,   8'd0  }},
      '{8'd0,   8'd0,   8'd255, 1'b1, '{4'd1,  8'd0,   8'd0,   8'd255}},
      '{8'd255, 8'd0,   8'd255, 1'b1, '{4'd3,  8'd255, 8'd0,   8'd255}},
      '{8'd0,   8'd255, 8'd0,   1'b1, '{4'd4,  8'd0,   8'd255, 8'd0  }},
      '{8'd0,   8'd255, 8'd255, 1'b1, '{4'd5,  8'd0,   8'd255, 8'd255}},
      '{8'd255, 8'd255, 8'd0,   1'b1, '{4'd6,  8'd255, 8'd255, 8'd0  }},
      '{8'd128, 8'd128, 8'd128, 1'b1, '{4'd8,  8'd128, 8'd128, 8'd128}},
      '{8'd0,   8'd0,   8'd128, 1'b1, '{4'd9,  8'd0,   8'd0,   8'd128}},
      '{8'd128, 8'd0,   8'd0,   1'b1, '{4'd10, 8'd128, 8'd0,   8'd0  }},
      '{8'd128, 8'd0,   8'd128, 1'b1, '{4'd11, 8'd128, 8'd0,   8'd128}},
      '{8'd0,   8'd128, 8'd0,   1'b1, '{4'd12, 8'd0,   8'd128, 8'd0  }},
      '{8'd0,   8'd128, 8'd128, 1'b1, '{4'd13, 8'd0,   8'd128, 8'd128}},
      '{8'd128, 8'd128, 8'd0,   1'b1, '{4'd14, 8'd128, 8'd128, 8'd0  }},
      '{8'd64,  8'd64,  8'd64,  1'b1, '{4'd15, 8'd64,  8'd64,  8'd64 }},
      // tie between black and dark gray: lowest index wins, error becomes 32
      '{8'd32,  8'd32,  8'd32,  1'b1, '{4'd0,  8'd0,   8'd0,   8'd0  }},
      // from here the carried error matters: predicted only
      '{8'd32,  8'd32,  8'd32,  1'b0, '0},
      '{8'd96,  8'd96,  8'd96,  1'b0, '0},
      '{8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{8'd200, 8'd200, 8'd200, 1'b0, '0},
      '{8'd200, 8'd200, 8'd200, 1'b0, '0},
      '{8'd170, 8'd85,  8'd170, 1'b0, '0},
      '{8'd85,  8'd170, 8'd85,  1'b0, '0},
      '{8'd1,   8'd2,   8'd4,   1'b0, '0}
   };

   palette_quantizer_error_carry dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold an adjusted channel inside the range the search works on.
   function automatic int clamp_adjusted(input int v);
      if (v < pqec_pkg::ADJ_MIN) begin
         return pqec_pkg::ADJ_MIN;
      end
      if (v > pqec_pkg::ADJ_MAX) begin
         return pqec_pkg::ADJ_MAX;
      end
      return v;
   endfunction

   // Add the carried error, find the nearest palette entry (lowest index on
   // a tie) and keep the leftover error for the next pixel.
   function automatic pick_type nearest_color(input logic [pqec_pkg::CH_W-1:0] r,
                                              input logic [pqec_pkg::CH_W-1:0] g,
                                              input logic [pqec_pkg::CH_W-1:0] b);
      int       adj_r, adj_g, adj_b;
      int       dr, dg, db;
      int       sq_dist, best_dist, n, best;
      pick_type pick;
      adj_r = clamp_adjusted(int'(r) + int'(carry_red));
      adj_g = clamp_adjusted(int'(g) + int'(carry_green));
      adj_b = clamp_adjusted(int'(b) + int'(carry_blue));
      n = pqec_pkg::PALETTE_SIZE_DEF;
      if (n > pqec_pkg::PAL_DEPTH) begin
         n = pqec_pkg::PAL_DEPTH;
      end
      if (n < 1) begin
         n = 1;
      end
      best      = 0;
      best_dist = 0;
      for (int i = 0; i < n; i++) begin
         dr = adj_r - int'(pqec_pkg::PAL_RED[i]);
         dg = adj_g - int'(pqec_pkg::PAL_GREEN[i]);
         db = adj_b - int'(pqec_pkg::PAL_BLUE[i]);
         sq_dist = dr * dr + dg * dg + db * db;
         if (i == 0 || sq_dist < best_dist) begin
            best      = i;
            best_dist = sq_dist;
         end
      end
      carry_red   = pqec_pkg::s11_type'(adj_r - int'(pqec_pkg::PAL_RED[best]));
      carry_green = pqec_pkg::s11_type'(adj_g - int'(pqec_pkg::PAL_GREEN[best]));
      carry_blue  = pqec_pkg::s11_type'(adj_b - int'(pqec_pkg::PAL_BLUE[best]));
      pick.index = pqec_pkg::PAL_IDX_W'(best);
      pick.red   = pqec_pkg::PAL_RED[best];
      pick.green = pqec_pkg::PAL_GREEN[best];
      pick.blue  = pqec_pkg::PAL_BLUE[best];
      return pick;
   endfunction

   // Offset a palette channel by a small random amount, kept in 0..255.
   function automatic logic [pqec_pkg::CH_W-1:0] jitter(
         input logic [pqec_pkg::CH_W-1:0] base);
      int v;
      v = int'(base) + int'($urandom_range(32)) - 16;
      if (v < 0) begin
         v = 0;
      end
      if (v > 255) begin
         v = 255;
      end
      return pqec_pkg::CH_W'(v);
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Offer one pixel, with random idle cycles first; return after its transfer.
   task automatic send_pixel(input logic [pqec_pkg::CH_W-1:0] r,
                             input logic [pqec_pkg::CH_W-1:0] g,
                             input logic [pqec_pkg::CH_W-1:0] b,
                             input logic pinned, input pick_type want);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      pin_valid  <= pinned;
      pin_want   <= want;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // Drop valid and hold off until every expected result has come back.
   task automatic drain_pending();
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_picks.size() != 0);
   endtask

   // Send a run of random pixels: uniform noise, smooth raster ramps,
   // near-palette colors and channel extremes.
   task automatic run_phase(input int src_pct, input int snk_pct, input int count);
      int                        kind, k;
      logic [pqec_pkg::CH_W-1:0] r, g, b;
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            r = pqec_pkg::CH_W'($urandom_range(255));
            g = pqec_pkg::CH_W'($urandom_range(255));
            b = pqec_pkg::CH_W'($urandom_range(255));
         end else if (kind < 60) begin
            // advance a gradient along the row, as an image source would
            ramp_red   = ramp_red   + pqec_pkg::CH_W'($urandom_range(6));
            ramp_green = ramp_green + pqec_pkg::CH_W'($urandom_range(3));
            ramp_blue  = ramp_blue  - pqec_pkg::CH_W'($urandom_range(4));
            r = ramp_red;
            g = ramp_green;
            b = ramp_blue;
         end else if (kind < 85) begin
            k = $urandom_range(pqec_pkg::PAL_DEPTH - 1);
            r = jitter(pqec_pkg::PAL_RED[k]);
            g = jitter(pqec_pkg::PAL_GREEN[k]);
            b = jitter(pqec_pkg::PAL_BLUE[k]);
         end else begin
            r = $urandom_range(1) ? 8'd255 : 8'd0;
            g = $urandom_range(1) ? 8'd255 : 8'd0;
            b = $urandom_range(3) == 0 ? 8'd128 : ($urandom_range(1) ? 8'd255 : 8'd0);
         end
         send_pixel(r, g, b, 1'b0, '0);
      end
   endtask

   // Receiver: honor a long hold-off request first, otherwise stall at random.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   // Predict on every req transfer; a pinned row supplies its typed result.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predicted = nearest_color(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
         if (pin_valid) begin
            pending_picks.push_back(pin_want);
         end else begin
            pending_picks.push_back(predicted);
         end
      end
   end

   // Check every rsp transfer against the oldest pending result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_picks.size() == 0) begin
            $error("unexpected result transfer: rsp_tdata 0x%h", rsp_tdata);
            mismatch_count++;
         end else begin
            arrived_want = pending_picks.pop_front();
            check_field("red_out",       arrived_want.red,   rsp_tdata[7:0]);
            check_field("green_out",     arrived_want.green, rsp_tdata[15:8]);
            check_field("blue_out",      arrived_want.blue,  rsp_tdata[23:16]);
            check_field("palette_index", arrived_want.index, rsp_tdata[27:24]);
            check_field("zero fill",     0,                  rsp_tdata[31:28]);
         end
      end
   end

   // Watchdog: end the run if the traffic never completes.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("palette_quantizer_error_carry test failed");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table, under light idling on both sides.
      src_idle_pct = 20;
      snk_idle_pct = 20;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_pixel(directed_rows[i].red, directed_rows[i].green,
                    directed_rows[i].blue, directed_rows[i].pinned,
                    directed_rows[i].want);
      end
      drain_pending();

      // Sender idles lightly, receiver heavily; then the reverse.
      run_phase(27, 74, PHASE_ITEMS);
      drain_pending();
      run_phase(74, 27, PHASE_ITEMS);
      drain_pending();

      // No idling, but open with a long receiver hold-off so the block fills
      // up and back-pressures req while the sender keeps offering.
      hold_request = LONG_HOLD;
      run_phase(0, 0, PHASE_ITEMS);
      drain_pending();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("palette_quantizer_error_carry test passed");
      end else begin
         $display("palette_quantizer_error_carry test failed");
      end
      $finish;
   end

endmodule

>>> files.f
sv/pqec_pkg.sv
sv/pqec_adjust.sv
sv/pqec_search.sv
sv/palette_quantizer_error_carry.sv
bench/tb.sv
